// ===== rtl/core/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// shared widths, carry record, rounding and saturation helpers for the sphere-cylinder
// contact pipeline
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int CW     = 32;  // coordinate width
  localparam int AW     = 18;  // axis / normal width
  localparam int RW     = 31;  // radius width
  localparam int DW     = 33;  // center offset width
  localparam int PRJ_W  = 39;  // projection width
  localparam int PW     = 38;  // perpendicular offset width
  localparam int MW     = 37;  // offset magnitude width
  localparam int BW     = 40;  // axis foot point width
  localparam int RAD_W  = 76;  // sum of squares width
  localparam int ROOT_W = 38;  // distance width
  localparam int NUM_W  = 54;  // dividend width
  localparam int QW     = 17;  // normal magnitude width
  localparam int FRAC   = 16;

  typedef struct packed {
    logic [2:0][CW-1:0] s;
    logic [2:0][BW-1:0] base;
    logic [RW-1:0]      rs;
    logic [RW-1:0]      rc;
    logic [2:0]         pneg;
    logic [2:0][MW-1:0] pmag;
    logic               degen;
  } carry_t;

  // round half up, then drop the fraction bits
  function automatic logic signed [47:0] rnd16(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x + 64'sd32768;
    return 48'(y >>> FRAC);
  endfunction

  function automatic logic signed [CW-1:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return 32'(x);
  endfunction

endpackage

// ===== rtl/core/sphere_cylinder_contact_top.sv =====
// ----------------------------------------------------------------------------
// sphere_cylinder_contact_top
// sphere versus infinite cylinder contact: depth, normal and contact points
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   sphere, cylinder, axis, radii
// out      output     out_valid_o / out_stall_i hit, degenerate, depth, normal, points
//
// one item per cycle while the output is not stalled; the pipe has 7 front stages, 38 square root stages,
// 1 setup stage, 17 divider stages and 2 back stages
// the bit-per-stage square root and divider set the depth of the pipe
// reset clears the valid bits only
// a stalled output freezes the whole pipe; bubbles still move forward
// ----------------------------------------------------------------------------
module sphere_cylinder_contact_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [scc_pkg::CW-1:0]     sphere_x_i,
  input  logic signed [scc_pkg::CW-1:0]     sphere_y_i,
  input  logic signed [scc_pkg::CW-1:0]     sphere_z_i,
  input  logic        [scc_pkg::RW-1:0]     sphere_radius_i,
  input  logic signed [scc_pkg::CW-1:0]     cylinder_x_i,
  input  logic signed [scc_pkg::CW-1:0]     cylinder_y_i,
  input  logic signed [scc_pkg::CW-1:0]     cylinder_z_i,
  input  logic signed [scc_pkg::AW-1:0]     axis_x_i,
  input  logic signed [scc_pkg::AW-1:0]     axis_y_i,
  input  logic signed [scc_pkg::AW-1:0]     axis_z_i,
  input  logic        [scc_pkg::RW-1:0]     cylinder_radius_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic                              degenerate_o,
  output logic signed [scc_pkg::CW-1:0]     depth_o,
  output logic signed [scc_pkg::AW-1:0]     normal_x_o,
  output logic signed [scc_pkg::AW-1:0]     normal_y_o,
  output logic signed [scc_pkg::AW-1:0]     normal_z_o,
  output logic signed [scc_pkg::CW-1:0]     sphere_point_x_o,
  output logic signed [scc_pkg::CW-1:0]     sphere_point_y_o,
  output logic signed [scc_pkg::CW-1:0]     sphere_point_z_o,
  output logic signed [scc_pkg::CW-1:0]     cyl_point_x_o,
  output logic signed [scc_pkg::CW-1:0]     cyl_point_y_o,
  output logic signed [scc_pkg::CW-1:0]     cyl_point_z_o
);
  import scc_pkg::*;

  logic en;
  logic out_v_q;

  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  logic signed [CW-1:0] s_in [3];
  logic signed [CW-1:0] c_in [3];
  logic signed [AW-1:0] a_in [3];

  assign s_in[0] = sphere_x_i;
  assign s_in[1] = sphere_y_i;
  assign s_in[2] = sphere_z_i;
  assign c_in[0] = cylinder_x_i;
  assign c_in[1] = cylinder_y_i;
  assign c_in[2] = cylinder_z_i;
  assign a_in[0] = axis_x_i;
  assign a_in[1] = axis_y_i;
  assign a_in[2] = axis_z_i;

  // stage 1: offsets and dot product terms
  logic                 v1_q;
  logic signed [CW-1:0] s1_q [3];
  logic signed [CW-1:0] c1_q [3];
  logic signed [AW-1:0] a1_q [3];
  logic signed [DW-1:0] d1_q [3];
  logic signed [50:0]   dp1_q [3];
  logic [RW-1:0]        rs1_q, rc1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_q[i]  <= s_in[i];
        c1_q[i]  <= c_in[i];
        a1_q[i]  <= a_in[i];
        d1_q[i]  <= DW'(s_in[i]) - DW'(c_in[i]);
        dp1_q[i] <= 51'((DW'(s_in[i]) - DW'(c_in[i])) * a_in[i]);
      end
      rs1_q <= sphere_radius_i;
      rc1_q <= cylinder_radius_i;
    end
  end

  // stage 2: axis coordinate t
  logic                 v2_q;
  logic signed [CW-1:0] s2_q [3];
  logic signed [CW-1:0] c2_q [3];
  logic signed [AW-1:0] a2_q [3];
  logic signed [DW-1:0] d2_q [3];
  logic signed [36:0]   t2_q;
  logic [RW-1:0]        rs2_q, rc2_q;
  logic signed [63:0]   tq;

  assign tq = 64'(dp1_q[0]) + 64'(dp1_q[1]) + 64'(dp1_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q  <= s1_q;
      c2_q  <= c1_q;
      a2_q  <= a1_q;
      d2_q  <= d1_q;
      t2_q  <= 37'(rnd16(tq));
      rs2_q <= rs1_q;
      rc2_q <= rc1_q;
    end
  end

  // stage 3: a * t
  logic                 v3_q;
  logic signed [CW-1:0] s3_q [3];
  logic signed [CW-1:0] c3_q [3];
  logic signed [DW-1:0] d3_q [3];
  logic signed [54:0]   at3_q [3];
  logic [RW-1:0]        rs3_q, rc3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        at3_q[i] <= 55'(a2_q[i] * t2_q);
      end
      s3_q  <= s2_q;
      c3_q  <= c2_q;
      d3_q  <= d2_q;
      rs3_q <= rs2_q;
      rc3_q <= rc2_q;
    end
  end

  // stage 4: projection, perpendicular offset, axis foot point
  logic                 v4_q;
  carry_t               c4_q;
  carry_t               c4_d;
  logic signed [PRJ_W-1:0] proj [3];
  logic signed [PW-1:0]    pv [3];

  always_comb begin
    c4_d = '0;
    for (int i = 0; i < 3; i++) begin
      proj[i]      = PRJ_W'(rnd16(64'(at3_q[i])));
      pv[i]        = PW'(40'(d3_q[i]) - 40'(proj[i]));
      c4_d.s[i]    = s3_q[i];
      c4_d.base[i] = BW'(BW'(c3_q[i]) + BW'(proj[i]));
      c4_d.pneg[i] = pv[i][PW-1];
      c4_d.pmag[i] = pv[i][PW-1] ? MW'(-pv[i]) : MW'(pv[i]);
    end
    c4_d.rs    = rs3_q;
    c4_d.rc    = rc3_q;
    c4_d.degen = (pv[0] == '0) && (pv[1] == '0) && (pv[2] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) c4_q <= c4_d;
  end

  // stage 5: partial products of the squares
  logic        v5_q;
  carry_t      c5_q;
  logic [33:0] hh5_q [3];
  logic [36:0] hl5_q [3];
  logic [39:0] ll5_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh5_q[i] <= c4_q.pmag[i][36:20] * c4_q.pmag[i][36:20];
        hl5_q[i] <= 37'(c4_q.pmag[i][36:20] * c4_q.pmag[i][19:0]);
        ll5_q[i] <= c4_q.pmag[i][19:0] * c4_q.pmag[i][19:0];
      end
      c5_q <= c4_q;
    end
  end

  // stage 6: squares
  logic         v6_q;
  carry_t       c6_q;
  logic [73:0]  sq6_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq6_q[i] <= (74'(hh5_q[i]) << 40) + (74'(hl5_q[i]) << 21) + 74'(ll5_q[i]);
      end
      c6_q <= c5_q;
    end
  end

  // stage 7: sum of squares
  logic             v7_q;
  carry_t           c7_q;
  logic [RAD_W-1:0] rad7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (en) v7_q <= v6_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad7_q <= RAD_W'(sq6_q[0]) + RAD_W'(sq6_q[1]) + RAD_W'(sq6_q[2]);
      c7_q   <= c6_q;
    end
  end

  // square root, one result bit per stage
  logic              sr_v_q    [ROOT_W];
  carry_t            sr_c_q    [ROOT_W];
  logic [RAD_W-1:0]  sr_rem_q  [ROOT_W];
  logic [ROOT_W-1:0] sr_root_q [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - g;
    logic              v_in;
    carry_t            c_in;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W+1:0]  inc;
    logic [RAD_W+1:0]  rem_x;
    logic              take;

    if (g == 0) begin : g_first
      assign v_in    = v7_q;
      assign c_in    = c7_q;
      assign rem_in  = rad7_q;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = sr_v_q[g-1];
      assign c_in    = sr_c_q[g-1];
      assign rem_in  = sr_rem_q[g-1];
      assign root_in = sr_root_q[g-1];
    end

    // (r + 2^b)^2 - r^2
    assign inc   = ((RAD_W+2)'(root_in) << (B + 1)) | ((RAD_W+2)'(1) << (2 * B));
    assign rem_x = (RAD_W+2)'(rem_in);
    assign take  = rem_x >= inc;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sr_v_q[g] <= 1'b0;
      else if (en) sr_v_q[g] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_c_q[g]    <= c_in;
        sr_rem_q[g]  <= take ? RAD_W'(rem_x - inc) : rem_in;
        sr_root_q[g] <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
      end
    end
  end

  // stage 8: depth and divider setup
  logic                   v8_q;
  carry_t                 c8_q;
  logic [ROOT_W-1:0]      dist8_q;
  logic signed [CW-1:0]   dep8_q;
  logic                   hit8_q;
  logic [2:0][NUM_W-1:0]  num8_q;
  logic [ROOT_W-1:0]      dist7;
  carry_t                 csr;
  logic signed [BW-1:0]   dep_w;

  assign dist7 = sr_root_q[ROOT_W-1];
  assign csr   = sr_c_q[ROOT_W-1];
  assign dep_w = BW'(dist7) - BW'(csr.rs) - BW'(csr.rc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (en) v8_q <= sr_v_q[ROOT_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c8_q    <= csr;
      dist8_q <= dist7;
      dep8_q  <= sat32(64'(dep_w));
      hit8_q  <= dep_w <= 0;
      for (int i = 0; i < 3; i++) begin
        num8_q[i] <= (NUM_W'(csr.pmag[i]) << FRAC) + NUM_W'(dist7 >> 1);
      end
    end
  end

  // restoring divider, one quotient bit per stage, three lanes
  logic                  dv_v_q    [QW];
  carry_t                dv_c_q    [QW];
  logic [ROOT_W-1:0]     dv_dist_q [QW];
  logic signed [CW-1:0]  dv_dep_q  [QW];
  logic                  dv_hit_q  [QW];
  logic [2:0][NUM_W-1:0] dv_rem_q  [QW];
  logic [2:0][QW-1:0]    dv_quo_q  [QW];

  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int K = QW - 1 - g;
    logic                  v_in;
    carry_t                c_in;
    logic [ROOT_W-1:0]     dist_in;
    logic signed [CW-1:0]  dep_in;
    logic                  hit_in;
    logic [2:0][NUM_W-1:0] rem_in;
    logic [2:0][QW-1:0]    quo_in;
    logic [NUM_W-1:0]      cmp;
    logic [2:0][NUM_W-1:0] rem_d;
    logic [2:0][QW-1:0]    quo_d;

    if (g == 0) begin : g_first
      assign v_in    = v8_q;
      assign c_in    = c8_q;
      assign dist_in = dist8_q;
      assign dep_in  = dep8_q;
      assign hit_in  = hit8_q;
      assign rem_in  = num8_q;
      assign quo_in  = '0;
    end else begin : g_next
      assign v_in    = dv_v_q[g-1];
      assign c_in    = dv_c_q[g-1];
      assign dist_in = dv_dist_q[g-1];
      assign dep_in  = dv_dep_q[g-1];
      assign hit_in  = dv_hit_q[g-1];
      assign rem_in  = dv_rem_q[g-1];
      assign quo_in  = dv_quo_q[g-1];
    end

    assign cmp = NUM_W'(dist_in) << K;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= cmp) begin
          rem_d[i] = rem_in[i] - cmp;
          quo_d[i] = quo_in[i] | (QW'(1) << K);
        end else begin
          rem_d[i] = rem_in[i];
          quo_d[i] = quo_in[i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[g] <= 1'b0;
      else if (en) dv_v_q[g] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_c_q[g]    <= c_in;
        dv_dist_q[g] <= dist_in;
        dv_dep_q[g]  <= dep_in;
        dv_hit_q[g]  <= hit_in;
        dv_rem_q[g]  <= rem_d;
        dv_quo_q[g]  <= quo_d;
      end
    end
  end

  // stage 9: signed normal and radius products
  logic                 v9_q;
  carry_t               c9_q;
  logic signed [CW-1:0] dep9_q;
  logic                 hit9_q;
  logic signed [AW-1:0] n9_q  [3];
  logic signed [49:0]   ps9_q [3];
  logic signed [49:0]   pc9_q [3];
  logic signed [AW-1:0] n_w   [3];
  carry_t               cdv;
  logic                 use_n;

  assign cdv   = dv_c_q[QW-1];
  assign use_n = dv_hit_q[QW-1] && !cdv.degen;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!use_n) n_w[i] = '0;
      // the normal points from the center back toward the axis
      else if (cdv.pneg[i]) n_w[i] = AW'(dv_quo_q[QW-1][i]);
      else n_w[i] = -AW'(dv_quo_q[QW-1][i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v9_q <= 1'b0;
    else if (en) v9_q <= dv_v_q[QW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c9_q   <= cdv;
      dep9_q <= dv_dep_q[QW-1];
      hit9_q <= dv_hit_q[QW-1];
      for (int i = 0; i < 3; i++) begin
        n9_q[i]  <= n_w[i];
        ps9_q[i] <= 50'($signed({1'b0, cdv.rs}) * n_w[i]);
        pc9_q[i] <= 50'($signed({1'b0, cdv.rc}) * n_w[i]);
      end
    end
  end

  // stage 10: contact points, output register
  logic                 hit_q, degen_q;
  logic signed [CW-1:0] dep_q;
  logic signed [AW-1:0] n_q  [3];
  logic signed [CW-1:0] sp_q [3];
  logic signed [CW-1:0] cp_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= v9_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q   <= hit9_q;
      degen_q <= c9_q.degen;
      dep_q   <= dep9_q;
      for (int i = 0; i < 3; i++) begin
        if (hit9_q) begin
          n_q[i]  <= n9_q[i];
          sp_q[i] <= sat32(64'($signed(c9_q.s[i])) + 64'(rnd16(64'(ps9_q[i]))));
          cp_q[i] <= sat32(64'($signed(c9_q.base[i])) + 64'(rnd16(64'(pc9_q[i]))));
        end else begin
          n_q[i]  <= '0;
          sp_q[i] <= '0;
          cp_q[i] <= '0;
        end
      end
    end
  end

  assign out_valid_o      = out_v_q;
  assign hit_o            = hit_q;
  assign degenerate_o     = degen_q;
  assign depth_o          = dep_q;
  assign normal_x_o       = n_q[0];
  assign normal_y_o       = n_q[1];
  assign normal_z_o       = n_q[2];
  assign sphere_point_x_o = sp_q[0];
  assign sphere_point_y_o = sp_q[1];
  assign sphere_point_z_o = sp_q[2];
  assign cyl_point_x_o    = cp_q[0];
  assign cyl_point_y_o    = cp_q[1];
  assign cyl_point_z_o    = cp_q[2];

  a_degen_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> hit_o)
    else $error("degenerate item without hit");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> normal_x_o == 0 && normal_y_o == 0 && normal_z_o == 0
      && depth_o > 0)
    else $error("miss with nonzero normal or nonpositive depth");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(depth_o) && $stable(hit_o))
    else $error("stalled item changed");

endmodule

// ===== sim/sphere_cylinder_contact_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_cylinder_contact_checker
// watches both channels of the contact pipe, computes the expected contact
// for each accepted item in exact integer arithmetic and compares results
// ----------------------------------------------------------------------------
module sphere_cylinder_contact_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic signed [scc_pkg::CW-1:0] sphere_x_i,
  input  logic signed [scc_pkg::CW-1:0] sphere_y_i,
  input  logic signed [scc_pkg::CW-1:0] sphere_z_i,
  input  logic        [scc_pkg::RW-1:0] sphere_radius_i,
  input  logic signed [scc_pkg::CW-1:0] cylinder_x_i,
  input  logic signed [scc_pkg::CW-1:0] cylinder_y_i,
  input  logic signed [scc_pkg::CW-1:0] cylinder_z_i,
  input  logic signed [scc_pkg::AW-1:0] axis_x_i,
  input  logic signed [scc_pkg::AW-1:0] axis_y_i,
  input  logic signed [scc_pkg::AW-1:0] axis_z_i,
  input  logic        [scc_pkg::RW-1:0] cylinder_radius_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          hit_i,
  input  logic                          degenerate_i,
  input  logic signed [scc_pkg::CW-1:0] depth_i,
  input  logic signed [scc_pkg::AW-1:0] normal_x_i,
  input  logic signed [scc_pkg::AW-1:0] normal_y_i,
  input  logic signed [scc_pkg::AW-1:0] normal_z_i,
  input  logic signed [scc_pkg::CW-1:0] sphere_point_x_i,
  input  logic signed [scc_pkg::CW-1:0] sphere_point_y_i,
  input  logic signed [scc_pkg::CW-1:0] sphere_point_z_i,
  input  logic signed [scc_pkg::CW-1:0] cyl_point_x_i,
  input  logic signed [scc_pkg::CW-1:0] cyl_point_y_i,
  input  logic signed [scc_pkg::CW-1:0] cyl_point_z_i,
  output int                            errors_o,
  output int                            pending_o,
  output int                            hits_o,
  output int                            degens_o
);
  import scc_pkg::*;

  typedef struct packed {
    logic                       hit;
    logic                       degen;
    logic signed [CW-1:0]       depth;
    logic signed [2:0][AW-1:0]  nrm;
    logic signed [2:0][CW-1:0]  sp;
    logic signed [2:0][CW-1:0]  cp;
  } contact_t;

  contact_t contact_q[$];

  function automatic longint round_q16(longint x);
    longint y;
    y = x + 64'sd32768;
    return y >>> 16;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic [79:0] floor_sqrt(logic [127:0] v);
    logic [79:0]  r;
    logic [79:0]  c;
    r = '0;
    for (int b = 39; b >= 0; b--) begin
      c = r | (80'd1 << b);
      if (128'(c) * 128'(c) <= v) r = c;
    end
    return r;
  endfunction

  function automatic contact_t predict_contact(
      longint s[3], longint cyl[3], longint ax[3], longint rs, longint rc);
    contact_t     e;
    longint       d[3], proj[3], p[3], nv[3];
    longint       tq, t, root_len, dep;
    logic [127:0] sq;
    logic [127:0] m;
    logic [127:0] q;
    tq = 0;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = s[i] - cyl[i];
      tq += d[i] * ax[i];
    end
    t = round_q16(tq);
    for (int i = 0; i < 3; i++) begin
      proj[i] = round_q16(ax[i] * t);
      p[i] = d[i] - proj[i];
      m = 128'(p[i] < 0 ? -p[i] : p[i]);
      sq += m * m;
      nv[i] = 0;
    end
    root_len = longint'(floor_sqrt(sq));
    dep = root_len - rs - rc;
    e = '0;
    e.hit = dep <= 0;
    e.degen = sq == 0;
    e.depth = 32'(clamp32(dep));
    if (e.hit && !e.degen) begin
      for (int i = 0; i < 3; i++) begin
        m = 128'(p[i] < 0 ? -p[i] : p[i]);
        q = ((m << 16) + 128'(root_len / 2)) / 128'(root_len);
        nv[i] = p[i] < 0 ? longint'(q) : -longint'(q);
      end
    end
    if (e.hit) begin
      for (int i = 0; i < 3; i++) begin
        e.nrm[i] = AW'(nv[i]);
        e.sp[i] = 32'(clamp32(s[i] + round_q16(rs * nv[i])));
        e.cp[i] = 32'(clamp32(cyl[i] + proj[i] + round_q16(rc * nv[i])));
      end
    end
    return e;
  endfunction

  task automatic report(string what, longint want, longint got);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    hits_o = 0;
    degens_o = 0;
  end

  assign pending_o = contact_q.size();

  always @(posedge clk_i) begin
    longint   s[3], cyl[3], ax[3];
    contact_t w;
    contact_t g;
    if (rst_ni && in_valid_i && !in_stall_i) begin
      s = '{sphere_x_i, sphere_y_i, sphere_z_i};
      cyl = '{cylinder_x_i, cylinder_y_i, cylinder_z_i};
      ax = '{axis_x_i, axis_y_i, axis_z_i};
      contact_q.insert(contact_q.size(),
                       predict_contact(s, cyl, ax, longint'(sphere_radius_i),
                                       longint'(cylinder_radius_i)));
    end
    if (rst_ni && out_valid_i && !out_stall_i) begin
      g.hit = hit_i;
      g.degen = degenerate_i;
      g.depth = depth_i;
      g.nrm = {normal_z_i, normal_y_i, normal_x_i};
      g.sp = {sphere_point_z_i, sphere_point_y_i, sphere_point_x_i};
      g.cp = {cyl_point_z_i, cyl_point_y_i, cyl_point_x_i};
      if (contact_q.size() == 0) begin
        $display("%0t: result with no item pending", $time);
        errors_o++;
      end else begin
        w = contact_q.pop_front();
        hits_o += g.hit;
        degens_o += g.degen;
        if (w.hit !== g.hit) report("hit", w.hit, g.hit);
        if (w.degen !== g.degen) report("degenerate", w.degen, g.degen);
        if (w.depth !== g.depth) report("depth", w.depth, g.depth);
        for (int i = 0; i < 3; i++) begin
          if (w.nrm[i] !== g.nrm[i])
            report($sformatf("normal[%0d]", i), $signed(w.nrm[i]), $signed(g.nrm[i]));
          if (w.sp[i] !== g.sp[i])
            report($sformatf("sphere_point[%0d]", i), $signed(w.sp[i]), $signed(g.sp[i]));
          if (w.cp[i] !== g.cp[i])
            report($sformatf("cyl_point[%0d]", i), $signed(w.cp[i]), $signed(g.cp[i]));
        end
      end
    end
  end

endmodule

// ===== sim/sphere_cylinder_contact_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_cylinder_contact_top_tb
// drives directed and random sphere / cylinder pairs with random gaps and
// output stalls, including one long output hold-off; the checker compares
// every result against its own exact prediction
// ----------------------------------------------------------------------------
module sphere_cylinder_contact_top_tb;
  import scc_pkg::*;

  localparam int N_RANDOM   = 700;
  localparam int LATENCY    = 65;
  localparam int IDLE_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CW-1:0] sx = '0, sy = '0, sz = '0, cx = '0, cy = '0, cz = '0;
  logic signed [AW-1:0] ax = '0, ay = '0, az = '0;
  logic        [RW-1:0] rs = '0, rc = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic hit_o, degenerate_o;
  logic signed [CW-1:0] depth_o, spx, spy, spz, cpx, cpy, cpz;
  logic signed [AW-1:0] nx, ny, nz;
  int errors, pending, hits, degens;
  int items_sent = 0;
  int idle_cycles = 0;
  bit quiet_phase = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sphere_cylinder_contact_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .sphere_x_i(sx), .sphere_y_i(sy), .sphere_z_i(sz), .sphere_radius_i(rs),
    .cylinder_x_i(cx), .cylinder_y_i(cy), .cylinder_z_i(cz),
    .axis_x_i(ax), .axis_y_i(ay), .axis_z_i(az), .cylinder_radius_i(rc),
    .out_valid_o, .out_stall_i, .hit_o, .degenerate_o, .depth_o,
    .normal_x_o(nx), .normal_y_o(ny), .normal_z_o(nz),
    .sphere_point_x_o(spx), .sphere_point_y_o(spy), .sphere_point_z_o(spz),
    .cyl_point_x_o(cpx), .cyl_point_y_o(cpy), .cyl_point_z_o(cpz)
  );

  sphere_cylinder_contact_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .sphere_x_i(sx), .sphere_y_i(sy), .sphere_z_i(sz), .sphere_radius_i(rs),
    .cylinder_x_i(cx), .cylinder_y_i(cy), .cylinder_z_i(cz),
    .axis_x_i(ax), .axis_y_i(ay), .axis_z_i(az), .cylinder_radius_i(rc),
    .out_valid_i(out_valid_o), .out_stall_i, .hit_i(hit_o), .degenerate_i(degenerate_o),
    .depth_i(depth_o), .normal_x_i(nx), .normal_y_i(ny), .normal_z_i(nz),
    .sphere_point_x_i(spx), .sphere_point_y_i(spy), .sphere_point_z_i(spz),
    .cyl_point_x_i(cpx), .cyl_point_y_i(cpy), .cyl_point_z_i(cpz),
    .errors_o(errors), .pending_o(pending), .hits_o(hits), .degens_o(degens)
  );

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stalls, a quiet stretch, and one long hold-off
  initial begin
    int cyc;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc >= 300 && cyc < 500) out_stall_i <= 1'b1;
      else if (quiet_phase) out_stall_i <= 1'b0;
      else out_stall_i <= ($urandom_range(99) < 8);
    end
  end

  function automatic logic signed [AW-1:0] rand_axis();
    int k;
    k = $urandom_range(9);
    if (k == 0) return AW'($urandom);
    if (k == 1) return 18'sd65536;
    if (k == 2) return -18'sd65536;
    return AW'($signed($urandom_range(131072)) - 65536);
  endfunction

  function automatic logic signed [CW-1:0] rand_coord(bit near);
    if (near) return CW'($signed($urandom_range(1 << 24)) - (1 << 23));
    return CW'($urandom);
  endfunction

  task automatic send(logic signed [CW-1:0] s0, s1, s2, logic [RW-1:0] r0,
                      logic signed [CW-1:0] c0, c1, c2,
                      logic signed [AW-1:0] a0, a1, a2, logic [RW-1:0] r1);
    while (!quiet_phase && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sx <= s0; sy <= s1; sz <= s2; rs <= r0;
    cx <= c0; cy <= c1; cz <= c2;
    ax <= a0; ay <= a1; az <= a2; rc <= r1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  localparam logic signed [CW-1:0] CMAX = 32'sh7fffffff;
  localparam logic signed [CW-1:0] CMIN = 32'sh80000000;
  localparam logic [RW-1:0]        RMAX = '1;
  localparam logic signed [AW-1:0] ONE  = 18'sd65536;

  initial begin
    bit near;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: on-axis, touching, apart, extremes, odd axes
    send(0, 0, 0, 0, 0, 0, 0, 0, 0, ONE, 0);
    send(CMAX, 5, 9, 7, CMAX, 5, 9, 0, ONE, 0, 3);
    send(32'sh30000, 0, 0, 32'h10000, 0, 0, 0, 0, 0, ONE, 32'h20000);
    send(32'sh50000, 0, 0, 32'h10000, 0, 0, 0, 0, 0, ONE, 32'h20000);
    send(32'sh10000, 32'sh10000, 0, 32'h20000, 0, 0, 0, 0, 0, ONE, 32'h10000);
    send(CMAX, CMAX, CMAX, RMAX, CMIN, CMIN, CMIN, 0, 0, -ONE, RMAX);
    send(CMIN, CMAX, CMIN, RMAX, CMAX, CMIN, CMAX, ONE, 0, 0, 0);
    send(CMAX, CMIN, 0, 0, CMIN, CMAX, 0, -ONE, -ONE, -ONE, 0);
    send(CMAX, CMAX, CMAX, RMAX, 0, 0, 0, 0, 0, 0, RMAX);
    send(CMIN, CMIN, CMIN, RMAX, 0, 0, 0, 0, 0, 0, RMAX);
    send(-32'sd1, 0, 0, 1, 0, 0, 0, 18'sh1ffff, 18'sh20000, 18'sh3ffff, 0);
    send(12345, -6789, 4242, 100, -99, 77, 3, 18'sd46341, 18'sd46341, 0, 50);
    send(-32'sh70000, 32'sh20000, 0, 32'h80000, 0, 0, 0, 0, -ONE, 0, 0);
    send(-32'sh70000, 32'sh20000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      near = $urandom_range(3) != 0;
      quiet_phase = i >= 400 && i < 500;
      send(rand_coord(near), rand_coord(near), rand_coord(near),
           near ? RW'($urandom_range(1 << 23)) : RW'($urandom),
           rand_coord(near), rand_coord(near), rand_coord(near),
           rand_axis(), rand_axis(), rand_axis(),
           near ? RW'($urandom_range(1 << 23)) : RW'($urandom));
    end
    quiet_phase = 0;
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("sent %0d items: %0d hits, %0d degenerate, with random gaps and stalls",
             items_sent, hits, degens);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
